>>> hdl/aabb_pkg.sv
`timescale 1ns / 1ps

package aabb_pkg;

  // default geometry of the fixed-point coordinates
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // headroom above the coordinate width for exact intermediate sums
  localparam int unsigned GUARD_BITS = 4;

  // configuration port
  localparam int unsigned GAP_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = GAP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_GAP    = 1'b1;

  // push direction codes as seen on push_axis
  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2
  } axis_e;

  // resolution decision handed from the decide logic to the correction stages
  typedef struct packed {
    axis_e axis;
    logic  neg;   // box one moves toward smaller coordinates
  } push_t;

endpackage

>>> hdl/aabb_decide.sv
`timescale 1ns / 1ps

module aabb_decide import aabb_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   overlap_i,
  input  logic                                   x_before_i,
  input  logic                                   y_before_i,
  input  logic                                   left_i,
  input  logic                                   top_i,
  input  logic                                   split_mode_i,
  input  logic signed [COORD_BITS+GUARD_BITS-1:0] dx_i,
  input  logic signed [COORD_BITS+GUARD_BITS-1:0] dy_i,
  output push_t                                  push_o
);

  logic both_before;
  logic x_eff;
  logic y_eff;

  // in split mode a pair that overlapped on both axes is treated as a corner
  assign both_before = x_before_i & y_before_i;
  assign x_eff       = x_before_i & ~(both_before & split_mode_i);
  assign y_eff       = y_before_i & ~(both_before & split_mode_i);

  // pick the push axis and direction
  always_comb begin
    push_o.axis = AXIS_NONE;
    push_o.neg  = 1'b0;
    if (!overlap_i || (x_eff && y_eff)) begin
      push_o.axis = AXIS_NONE;
    end else if (x_eff) begin
      // came in along y
      push_o.axis = AXIS_Y;
      push_o.neg  = top_i;
    end else if (y_eff) begin
      // came in along x
      push_o.axis = AXIS_X;
      push_o.neg  = left_i;
    end else if (dx_i > dy_i) begin
      // corner, shallower along y
      push_o.axis = AXIS_Y;
      push_o.neg  = top_i;
    end else begin
      push_o.axis = AXIS_X;
      push_o.neg  = left_i;
    end
  end

endmodule

>>> hdl/aabb_swept_collision_resolve.sv
`timescale 1ns / 1ps

// Swept AABB collision resolver for box pairs in signed fixed point
// (COORD_BITS wide, FRAC_BITS fraction bits). A five-stage pipeline takes one
// pair per clock while the output side does not stall; each pair passes the
// stage registers one to five in order, the fifth being the output register.
// Stage one forms the penetration sums and the previous positions, stage two
// the per-axis overlap tests and depths, stage three the push decision, stage
// four the correction terms, and stage five the halving, the new coordinates
// and saturation into the output register. A stall on the output holds a full
// stage only when every stage after it is full too; the other stages keep
// moving. Configuration (split_mode at index 0, separation_gap at index 1)
// is read live by the pipeline and must only be written while no word is in
// flight.
module aabb_swept_collision_resolve import aabb_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] first_x_i,
  input  logic signed [COORD_BITS-1:0] first_y_i,
  input  logic [COORD_BITS-2:0]        first_w_i,
  input  logic [COORD_BITS-2:0]        first_h_i,
  input  logic signed [COORD_BITS-1:0] first_vx_i,
  input  logic signed [COORD_BITS-1:0] first_vy_i,
  input  logic signed [COORD_BITS-1:0] second_x_i,
  input  logic signed [COORD_BITS-1:0] second_y_i,
  input  logic [COORD_BITS-2:0]        second_w_i,
  input  logic [COORD_BITS-2:0]        second_h_i,
  input  logic signed [COORD_BITS-1:0] second_vx_i,
  input  logic signed [COORD_BITS-1:0] second_vy_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] new_first_x_o,
  output logic signed [COORD_BITS-1:0] new_first_y_o,
  output logic signed [COORD_BITS-1:0] new_second_x_o,
  output logic signed [COORD_BITS-1:0] new_second_y_o,
  output logic                         corrected_o,
  output logic [1:0]                   push_axis_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CW = COORD_BITS + GUARD_BITS;
  localparam int unsigned GapRaw   = ((1 << FRAC_BITS) + 50) / 100;
  localparam int unsigned GapReset = (GapRaw > 65535) ? 65535 : GapRaw;
  localparam logic signed [CB-1:0] CoordMax = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CoordMin = {1'b1, {(CB-1){1'b0}}};

  // clamp an exact sum into the coordinate range
  function automatic logic signed [CB-1:0] sat(input logic signed [CW-1:0] v);
    logic signed [CB-1:0] r;
    if (v > CW'(CoordMax)) begin
      r = CoordMax;
    end else if (v < CW'(CoordMin)) begin
      r = CoordMin;
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic             split_mode_q;
  logic [GAP_W-1:0] sep_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_mode_q <= 1'b0;
      sep_gap_q    <= GAP_W'(GapReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPLIT_MODE: split_mode_q <= cfg_data_i[0];
        CFG_SEP_GAP:    sep_gap_q    <= cfg_data_i[GAP_W-1:0];
        default:        ;
      endcase
    end
  end

  logic signed [CW-1:0] gap;
  assign gap = CW'($signed({1'b0, sep_gap_q}));

  // stage valids and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: edge differences and previous positions
  logic signed [CW-1:0] x1e, y1e, w1e, h1e, x2e, y2e, w2e, h2e;
  logic signed [CW-1:0] dxl_d, dxr_d, dyl_d, dyr_d, ox1_d, oy1_d, ox2_d, oy2_d;

  assign x1e = CW'(first_x_i);
  assign y1e = CW'(first_y_i);
  assign w1e = CW'($signed({1'b0, first_w_i}));
  assign h1e = CW'($signed({1'b0, first_h_i}));
  assign x2e = CW'(second_x_i);
  assign y2e = CW'(second_y_i);
  assign w2e = CW'($signed({1'b0, second_w_i}));
  assign h2e = CW'($signed({1'b0, second_h_i}));

  assign dxl_d = x1e + w1e - x2e;
  assign dxr_d = x2e + w2e - x1e;
  assign dyl_d = y1e + h1e - y2e;
  assign dyr_d = y2e + h2e - y1e;
  assign ox1_d = x1e - CW'(first_vx_i);
  assign oy1_d = y1e - CW'(first_vy_i);
  assign ox2_d = x2e - CW'(second_vx_i);
  assign oy2_d = y2e - CW'(second_vy_i);

  logic signed [CW-1:0] s1_dxl_q, s1_dxr_q, s1_dyl_q, s1_dyr_q;
  logic signed [CW-1:0] s1_ox1_q, s1_oy1_q, s1_ox2_q, s1_oy2_q;
  logic signed [CB-1:0] s1_x1_q, s1_y1_q, s1_x2_q, s1_y2_q;
  logic [CB-2:0]        s1_w1_q, s1_h1_q, s1_w2_q, s1_h2_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_dxl_q <= dxl_d;
      s1_dxr_q <= dxr_d;
      s1_dyl_q <= dyl_d;
      s1_dyr_q <= dyr_d;
      s1_ox1_q <= ox1_d;
      s1_oy1_q <= oy1_d;
      s1_ox2_q <= ox2_d;
      s1_oy2_q <= oy2_d;
      s1_x1_q  <= first_x_i;
      s1_y1_q  <= first_y_i;
      s1_x2_q  <= second_x_i;
      s1_y2_q  <= second_y_i;
      s1_w1_q  <= first_w_i;
      s1_h1_q  <= first_h_i;
      s1_w2_q  <= second_w_i;
      s1_h2_q  <= second_h_i;
    end
  end

  // stage 2: overlap now, overlap before, corner depths
  logic signed [CW-1:0] s1_w1e, s1_h1e, s1_w2e, s1_h2e;
  logic ovl_d, xo_d, yo_d, left_d, top_d;
  logic signed [CW-1:0] dx_d, dy_d;

  assign s1_w1e = CW'($signed({1'b0, s1_w1_q}));
  assign s1_h1e = CW'($signed({1'b0, s1_h1_q}));
  assign s1_w2e = CW'($signed({1'b0, s1_w2_q}));
  assign s1_h2e = CW'($signed({1'b0, s1_h2_q}));

  assign ovl_d  = (s1_dxl_q > 0) && (s1_dxr_q > 0) && (s1_dyl_q > 0) && (s1_dyr_q > 0);
  assign xo_d   = (s1_ox1_q < s1_ox2_q + s1_w2e) && (s1_ox1_q + s1_w1e > s1_ox2_q);
  assign yo_d   = (s1_oy1_q < s1_oy2_q + s1_h2e) && (s1_oy1_q + s1_h1e > s1_oy2_q);
  assign left_d = s1_ox1_q < s1_ox2_q;
  assign top_d  = s1_oy1_q < s1_oy2_q;
  assign dx_d   = left_d ? s1_dxl_q : s1_dxr_q;
  assign dy_d   = top_d ? s1_dyl_q : s1_dyr_q;

  logic s2_ovl_q, s2_xo_q, s2_yo_q, s2_left_q, s2_top_q;
  logic signed [CW-1:0] s2_dx_q, s2_dy_q;
  logic signed [CB-1:0] s2_x1_q, s2_y1_q, s2_x2_q, s2_y2_q;
  logic [CB-2:0]        s2_w1_q, s2_h1_q, s2_w2_q, s2_h2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_ovl_q  <= ovl_d;
      s2_xo_q   <= xo_d;
      s2_yo_q   <= yo_d;
      s2_left_q <= left_d;
      s2_top_q  <= top_d;
      s2_dx_q   <= dx_d;
      s2_dy_q   <= dy_d;
      s2_x1_q   <= s1_x1_q;
      s2_y1_q   <= s1_y1_q;
      s2_x2_q   <= s1_x2_q;
      s2_y2_q   <= s1_y2_q;
      s2_w1_q   <= s1_w1_q;
      s2_h1_q   <= s1_h1_q;
      s2_w2_q   <= s1_w2_q;
      s2_h2_q   <= s1_h2_q;
    end
  end

  // stage 3: push decision
  push_t push_d;

  aabb_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .overlap_i    (s2_ovl_q),
    .x_before_i   (s2_xo_q),
    .y_before_i   (s2_yo_q),
    .left_i       (s2_left_q),
    .top_i        (s2_top_q),
    .split_mode_i (split_mode_q),
    .dx_i         (s2_dx_q),
    .dy_i         (s2_dy_q),
    .push_o       (push_d)
  );

  push_t                s3_push_q;
  logic signed [CB-1:0] s3_x1_q, s3_y1_q, s3_x2_q, s3_y2_q;
  logic [CB-2:0]        s3_w1_q, s3_h1_q, s3_w2_q, s3_h2_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_push_q <= push_d;
      s3_x1_q   <= s2_x1_q;
      s3_y1_q   <= s2_y1_q;
      s3_x2_q   <= s2_x2_q;
      s3_y2_q   <= s2_y2_q;
      s3_w1_q   <= s2_w1_q;
      s3_h1_q   <= s2_h1_q;
      s3_w2_q   <= s2_w2_q;
      s3_h2_q   <= s2_h2_q;
    end
  end

  // stage 4: correction terms along the chosen axis
  logic signed [CW-1:0] p1, s1, p2, s2;
  logic signed [CW-1:0] r1m0_d, dist_d;
  logic                 on_x;

  assign on_x = (s3_push_q.axis == AXIS_X);
  assign p1 = on_x ? CW'(s3_x1_q) : CW'(s3_y1_q);
  assign p2 = on_x ? CW'(s3_x2_q) : CW'(s3_y2_q);
  assign s1 = on_x ? CW'($signed({1'b0, s3_w1_q})) : CW'($signed({1'b0, s3_h1_q}));
  assign s2 = on_x ? CW'($signed({1'b0, s3_w2_q})) : CW'($signed({1'b0, s3_h2_q}));

  assign r1m0_d = s3_push_q.neg ? (p2 - s1 - gap) : (p2 + s2 + gap);
  assign dist_d = s3_push_q.neg ? (p1 + s1 - p2 + gap) : (p2 + s2 - p1 + gap);

  push_t                s4_push_q;
  logic signed [CW-1:0] s4_r1m0_q, s4_dist_q, s4_p1_q, s4_p2_q;
  logic signed [CB-1:0] s4_x1_q, s4_y1_q, s4_x2_q, s4_y2_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_push_q <= s3_push_q;
      s4_r1m0_q <= r1m0_d;
      s4_dist_q <= dist_d;
      s4_p1_q   <= p1;
      s4_p2_q   <= p2;
      s4_x1_q   <= s3_x1_q;
      s4_y1_q   <= s3_y1_q;
      s4_x2_q   <= s3_x2_q;
      s4_y2_q   <= s3_y2_q;
    end
  end

  // stage 5: halving, new coordinates, saturation
  logic signed [CW-1:0] half, r1, r2;
  logic signed [CW-1:0] nx1, ny1, nx2, ny2;

  assign half = s4_dist_q >>> 1;

  always_comb begin
    if (split_mode_q) begin
      r1 = s4_push_q.neg ? (s4_p1_q - half) : (s4_p1_q + half);
      r2 = s4_push_q.neg ? (s4_p2_q + half) : (s4_p2_q - half);
    end else begin
      r1 = s4_r1m0_q;
      r2 = s4_p2_q;
    end
    nx1 = CW'(s4_x1_q);
    ny1 = CW'(s4_y1_q);
    nx2 = CW'(s4_x2_q);
    ny2 = CW'(s4_y2_q);
    case (s4_push_q.axis)
      AXIS_X: begin
        nx1 = r1;
        nx2 = r2;
      end
      AXIS_Y: begin
        ny1 = r1;
        ny2 = r2;
      end
      default: ;
    endcase
  end

  logic signed [CB-1:0] out_x1_q, out_y1_q, out_x2_q, out_y2_q;
  axis_e                out_axis_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_x1_q   <= sat(nx1);
      out_y1_q   <= sat(ny1);
      out_x2_q   <= sat(nx2);
      out_y2_q   <= sat(ny2);
      out_axis_q <= s4_push_q.axis;
    end
  end

  assign out_valid_o    = v5_q;
  assign new_first_x_o  = out_x1_q;
  assign new_first_y_o  = out_y1_q;
  assign new_second_x_o = out_x2_q;
  assign new_second_y_o = out_y2_q;
  assign corrected_o    = (out_axis_q != AXIS_NONE);
  assign push_axis_o    = out_axis_q;

  // input is held off only while the first stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q)
    else $error("input stalled with an empty first stage");

  // a pair left unresolved leaves the output register with its first x and second y positions untouched
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5 && s4_push_q.axis == AXIS_NONE) |=>
      (new_first_x_o == $past(s4_x1_q) && new_second_y_o == $past(s4_y2_q)))
    else $error("unresolved pair changed its coordinates");

  // a word that cannot leave stays in the output stage
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && out_stall_i) |=> (v5_q && $stable(out_axis_q) && $stable(out_x1_q)))
    else $error("output stage lost a stalled word");

endmodule
